// ===== rtl/core/qctd_pkg.sv =====
package qctd_pkg;

    // Defaults for the top level parameters
    localparam int DEF_MAX_DEVICES = 8;
    localparam int DEF_COUNT_BITS  = 16;

    // Command codes as they arrive on the mode field
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_REQ   = 2'd2;

    // Classified command kinds carried through the queue
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_REQ   = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    // Configuration register indexes (paddr[2])
    localparam logic REG_DEVICE_COUNT = 1'b0;
    localparam logic REG_CHUNK_LEN    = 1'b1;

    // Reset values of the configuration registers
    localparam logic [3:0]  RST_DEVICE_COUNT = 4'd8;
    localparam logic [15:0] RST_CHUNK_LEN    = 16'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  device_sel;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  device_out;
        logic [15:0] slot;
        logic [15:0] task_id;
        logic [3:0]  active_devices;
        logic        last;
    } t_res;

    // Queue entry between front and back
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  device_sel;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef struct packed {
        logic [3:0]  device_count;
        logic [15:0] chunk_len;
        logic        chunk_wr;
    } t_cfg;

endpackage

// ===== rtl/core/qctd_front.sv =====
module qctd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  qctd_pkg::t_cmd i_cmd,
    output logic          o_busy,
    input  logic          i_pop,
    output qctd_pkg::t_q2b o_q2b
);

    qctd_pkg::t_item r_slot [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            acc;
    qctd_pkg::t_item item_in;

    assign o_busy = (r_cnt == 2'd2);
    assign acc    = i_start && !o_busy;

    // Classify the incoming beat
    always_comb begin
        item_in.device_sel = i_cmd.device_sel;
        item_in.value      = i_cmd.value;
        unique case (i_cmd.mode)
            qctd_pkg::MODE_LOAD:  item_in.kind = qctd_pkg::KIND_LOAD;
            qctd_pkg::MODE_START: item_in.kind = qctd_pkg::KIND_START;
            qctd_pkg::MODE_REQ:   item_in.kind = qctd_pkg::KIND_REQ;
            default:              item_in.kind = qctd_pkg::KIND_BAD;
        endcase
    end

    assign o_q2b.valid = (r_cnt != 2'd0);
    assign o_q2b.item  = r_slot[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(acc) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_slot[r_wp] <= item_in;
    end

endmodule

// ===== rtl/core/qctd_back.sv =====
module qctd_back #(
    parameter int MAX_DEVICES = qctd_pkg::DEF_MAX_DEVICES,
    parameter int COUNT_BITS  = qctd_pkg::DEF_COUNT_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qctd_pkg::t_cfg i_cfg,
    input  qctd_pkg::t_q2b i_q2b,
    output logic           o_pop,
    output logic           o_done,
    output qctd_pkg::t_res o_res
);

    localparam int CB  = COUNT_BITS;
    localparam int IW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int NW  = $clog2(MAX_DEVICES + 1);
    localparam int EW  = NW + 1;
    localparam int SW  = CB + 5;
    localparam int DCW = $clog2(CB + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_QUOTA = 3'd3;
    localparam logic [2:0] S_REQ   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CB-1:0] r_base  [MAX_DEVICES];
    logic [CB-1:0] n_base  [MAX_DEVICES];
    logic [CB-1:0] r_final [MAX_DEVICES];
    logic [CB-1:0] n_final [MAX_DEVICES];
    logic [CB-1:0] r_asg   [MAX_DEVICES];
    logic [CB-1:0] n_asg   [MAX_DEVICES];
    logic [CB-1:0] r_total, n_total;
    logic [CB-1:0] r_tcnt, n_tcnt;
    logic [IW-1:0] r_cur, n_cur;
    logic          r_run, n_run;
    logic [NW-1:0] r_used, n_used;
    logic          r_active, n_active;
    logic [15:0]   r_ccnt, n_ccnt;
    logic          r_dirty, n_dirty;
    logic [NW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_sum, n_sum;
    logic [16:0]   r_rem, n_rem;
    logic [CB-1:0] r_quo, n_quo;
    logic [15:0]   r_dvs, n_dvs;
    logic [DCW-1:0] r_dcnt, n_dcnt;
    logic          r_div_mod, n_div_mod;
    logic          r_done, n_done;
    qctd_pkg::t_res r_res, n_res;

    logic [NW-1:0] eff;
    logic [CB-1:0] total_in;
    logic [MAX_DEVICES-1:0] room;
    logic [NW-1:0] lim;
    logic [15:0]   ccnt_eff;
    logic          stay, rq_found, do_req;
    logic [IW-1:0] rq_dev;
    logic [EW-1:0] start_i, cand;
    logic [16:0]   div_t, c1;
    logic          div_ge;
    logic [SW-1:0] sum_nx;
    logic [CB-1:0] tcnt_nx;

    // Effective device count
    always_comb begin
        if (i_cfg.device_count == 4'd0) eff = NW'(1);
        else if (5'(i_cfg.device_count) > 5'(MAX_DEVICES)) eff = NW'(MAX_DEVICES);
        else eff = NW'(i_cfg.device_count);
    end

    assign total_in = CB'(i_q2b.item.value);
    assign ccnt_eff = (r_state == S_REQ) ? r_rem[15:0] : r_ccnt;

    // Device search: stay on the run or take the next device with room
    always_comb begin
        for (int d = 0; d < MAX_DEVICES; d++) room[d] = r_asg[d] < r_final[d];
        lim      = (r_used == '0) ? NW'(1) : r_used;
        stay     = r_run && room[r_cur] &&
                   (i_cfg.chunk_len == 16'd0 || ccnt_eff != 16'd0);
        start_i  = EW'(r_cur) + EW'(r_run);
        rq_found = stay;
        rq_dev   = r_cur;
        cand     = '0;
        if (!stay) begin
            for (int k = 0; k < MAX_DEVICES; k++) begin
                cand = start_i + EW'(k);
                if (cand >= EW'(lim)) cand = cand - EW'(lim);
                if (!rq_found && (EW'(k) < EW'(lim)) && room[IW'(cand)]) begin
                    rq_found = 1'b1;
                    rq_dev   = IW'(cand);
                end
            end
        end
    end

    // Divider step: one quotient bit per cycle
    assign div_t  = {r_rem[15:0], r_quo[CB-1]};
    assign div_ge = div_t >= {1'b0, r_dvs};
    assign sum_nx = r_sum + SW'(r_base[IW'(r_idx)]);
    assign tcnt_nx = r_tcnt + CB'(1);
    assign c1     = {1'b0, ccnt_eff} + 17'd1;

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_final   = r_final;
        n_asg     = r_asg;
        n_total   = r_total;
        n_tcnt    = r_tcnt;
        n_cur     = r_cur;
        n_run     = r_run;
        n_used    = r_used;
        n_active  = r_active;
        n_ccnt    = r_ccnt;
        n_dirty   = r_dirty;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvs     = r_dvs;
        n_dcnt    = r_dcnt;
        n_div_mod = r_div_mod;
        n_done    = 1'b0;
        n_res     = '0;
        o_pop     = 1'b0;
        do_req    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q2b.valid) begin
                    o_pop = 1'b1;
                    case (i_q2b.item.kind)
                        qctd_pkg::KIND_LOAD: begin
                            n_done = 1'b1;
                            if (5'(i_q2b.item.device_sel) < 5'(eff))
                                n_base[IW'(i_q2b.item.device_sel)] = total_in;
                            else
                                n_res.status = qctd_pkg::ST_BAD;
                        end
                        qctd_pkg::KIND_START: begin
                            for (int d = 0; d < MAX_DEVICES; d++) begin
                                n_final[d] = '0;
                                n_asg[d]   = '0;
                            end
                            n_tcnt   = '0;
                            n_cur    = '0;
                            n_run    = 1'b0;
                            n_total  = total_in;
                            n_active = 1'b0;
                            n_used   = '0;
                            n_ccnt   = '0;
                            n_dirty  = 1'b0;
                            if (33'(total_in) <= 33'(eff)) begin
                                for (int d = 0; d < MAX_DEVICES; d++)
                                    n_final[d] = CB'(33'(d) < 33'(total_in));
                                n_used   = NW'(total_in);
                                n_active = (total_in != '0);
                                n_done   = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_sum   = '0;
                                n_state = S_SUM;
                            end
                        end
                        qctd_pkg::KIND_REQ: begin
                            if (!r_active) begin
                                n_done       = 1'b1;
                                n_res.status = qctd_pkg::ST_IDLE;
                            end else if (r_dirty && i_cfg.chunk_len != 16'd0) begin
                                // rebuild tasks_done mod chunk after a chunk change
                                n_rem     = '0;
                                n_quo     = r_tcnt;
                                n_dvs     = i_cfg.chunk_len;
                                n_dcnt    = '0;
                                n_div_mod = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                do_req = 1'b1;
                            end
                        end
                        default: begin
                            n_done       = 1'b1;
                            n_res.status = qctd_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            // Sum base quotas, one device a cycle
            S_SUM: begin
                n_sum = sum_nx;
                n_idx = r_idx + NW'(1);
                if (r_idx == NW'(eff - NW'(1))) begin
                    if (sum_nx > SW'(r_total)) begin
                        n_done       = 1'b1;
                        n_res.status = qctd_pkg::ST_BAD;
                        n_state      = S_IDLE;
                    end else begin
                        n_rem     = '0;
                        n_quo     = CB'(SW'(r_total) - sum_nx);
                        n_dvs     = 16'(eff);
                        n_dcnt    = '0;
                        n_div_mod = 1'b0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? (div_t - {1'b0, r_dvs}) : div_t;
                n_quo  = {r_quo[CB-2:0], div_ge};
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(CB - 1)) n_state = r_div_mod ? S_REQ : S_QUOTA;
            end
            // Spread the remainder from device 0
            S_QUOTA: begin
                for (int d = 0; d < MAX_DEVICES; d++) begin
                    if (33'(d) < 33'(eff))
                        n_final[d] = r_base[d] + r_quo +
                                     CB'(33'(d) < 33'(r_rem[15:0]));
                end
                n_used   = eff;
                n_active = 1'b1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_REQ: begin
                n_dirty = 1'b0;
                n_ccnt  = r_rem[15:0];
                do_req  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Hand out one task
        if (do_req) begin
            n_done = 1'b1;
            if (!rq_found) begin
                n_active     = 1'b0;
                n_run        = 1'b0;
                n_res.status = qctd_pkg::ST_IDLE;
            end else begin
                n_cur              = rq_dev;
                n_res.device_out   = 3'(rq_dev);
                n_res.slot         = 16'(r_asg[rq_dev]);
                n_res.task_id      = 16'(r_tcnt);
                n_asg[rq_dev]      = r_asg[rq_dev] + CB'(1);
                n_tcnt             = tcnt_nx;
                n_run              = 1'b1;
                n_ccnt             = (c1 == {1'b0, i_cfg.chunk_len}) ? 16'd0 : c1[15:0];
                if (tcnt_nx == r_total) begin
                    n_res.last = 1'b1;
                    n_active   = 1'b0;
                    n_run      = 1'b0;
                end
            end
        end

        if (i_cfg.chunk_wr) n_dirty = 1'b1;
        n_res.active_devices = 4'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            for (int d = 0; d < MAX_DEVICES; d++) begin
                r_base[d]  <= '0;
                r_final[d] <= '0;
                r_asg[d]   <= '0;
            end
            r_total  <= '0;
            r_tcnt   <= '0;
            r_cur    <= '0;
            r_run    <= 1'b0;
            r_used   <= '0;
            r_active <= 1'b0;
            r_ccnt   <= '0;
            r_dirty  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_final  <= n_final;
            r_asg    <= n_asg;
            r_total  <= n_total;
            r_tcnt   <= n_tcnt;
            r_cur    <= n_cur;
            r_run    <= n_run;
            r_used   <= n_used;
            r_active <= n_active;
            r_ccnt   <= n_ccnt;
            r_dirty  <= n_dirty;
            r_done   <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_dcnt    <= n_dcnt;
        r_div_mod <= n_div_mod;
        r_res     <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/quota_chunk_task_distributor_core.sv =====
// Quota-based chunked task distributor. Commands (load quota, start job, request
// next task) are taken when start is high and busy is low into a two-entry queue;
// every command gives exactly one result, shown for one cycle with o_done, and
// the receiver cannot hold it off. A load or request is handled from the idle
// state and its result is registered. A job start whose total is at most the
// effective device count sets its quotas at once; otherwise it sums the base
// quotas (a bad status if they exceed the total), runs the bit-serial divider
// and then sets the final quotas. The first request on an active job after a
// chunk length write runs the same divider, if the length is nonzero, to rebuild
// the chunk position. busy rises only while the queue holds two commands.
module quota_chunk_task_distributor_core #(
    parameter int MAX_DEVICES = qctd_pkg::DEF_MAX_DEVICES,
    parameter int COUNT_BITS  = qctd_pkg::DEF_COUNT_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  qctd_pkg::t_cmd i_cmd,
    output logic           o_done,
    output qctd_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [3:0]     r_device_count;
    logic [15:0]    r_chunk_len;
    logic           wr;
    qctd_pkg::t_cfg cfg;
    qctd_pkg::t_q2b q2b;
    logic           pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_count <= qctd_pkg::RST_DEVICE_COUNT;
            r_chunk_len    <= qctd_pkg::RST_CHUNK_LEN;
        end else if (wr) begin
            if (paddr[2] == qctd_pkg::REG_DEVICE_COUNT) r_device_count <= pwdata[3:0];
            else r_chunk_len <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == qctd_pkg::REG_CHUNK_LEN) ? {16'd0, r_chunk_len}
                                                          : {28'd0, r_device_count};

    assign cfg.device_count = r_device_count;
    assign cfg.chunk_len    = r_chunk_len;
    assign cfg.chunk_wr     = wr && (paddr[2] == qctd_pkg::REG_CHUNK_LEN);

    qctd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .o_busy  (busy),
        .i_pop   (pop),
        .o_q2b   (q2b)
    );

    qctd_back #(
        .MAX_DEVICES (MAX_DEVICES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_q2b   (q2b),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/core/qctd_checker.sv =====
module qctd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_done,
    input qctd_pkg::t_res o_res,
    input logic           pready
);

    // No result in the cycle after reset
    a_no_done_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done) else $error("result right after reset");

    // Status code three is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.status != 2'd3)) else $error("bad status code");

    // A failed beat carries no assignment
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != qctd_pkg::ST_OK) |->
        (o_res.device_out == 3'd0 && o_res.slot == 16'd0 && o_res.task_id == 16'd0
         && !o_res.last)) else $error("failed beat has payload");

    // The final task comes only on a good beat that still reports active devices
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.last) |-> (o_res.status == qctd_pkg::ST_OK &&
        o_res.active_devices != 4'd0)) else $error("last on bad beat");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");

endmodule

bind quota_chunk_task_distributor_core qctd_checker u_qctd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_done  (o_done),
    .o_res   (o_res),
    .pready  (pready)
);

// ===== bench/quota_chunk_task_distributor_core_chk.sv =====
module quota_chunk_task_distributor_core_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  qctd_pkg::t_cmd i_cmd,
    input  logic           o_done,
    input  qctd_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             o_errors,
    output int             o_pending
);
    import qctd_pkg::*;

    localparam int NDEV = DEF_MAX_DEVICES;

    // shadow configuration
    logic [3:0]  dev_count;
    logic [15:0] chunk;

    // shadow distributor state
    logic [15:0] base_q [NDEV];
    logic [15:0] final_q[NDEV];
    logic [15:0] given  [NDEV];
    logic [15:0] job_total;
    logic [15:0] tasks_done;
    logic [2:0]  cur_dev;
    logic        run_open;
    logic [3:0]  used_devs;
    logic        job_active;

    t_res assign_q[$];

    assign o_pending = assign_q.size();

    function automatic int eff_devs();
        if (dev_count == 0) return 1;
        if (dev_count > NDEV) return NDEV;
        return dev_count;
    endfunction

    function automatic bit room(int d);
        return d < NDEV && given[d] < final_q[d];
    endfunction

    task automatic clear_state();
        for (int d = 0; d < NDEV; d++) begin
            base_q[d]  = '0;
            final_q[d] = '0;
            given[d]   = '0;
        end
        job_total  = '0;
        tasks_done = '0;
        cur_dev    = '0;
        run_open   = 1'b0;
        used_devs  = '0;
        job_active = 1'b0;
    endtask

    // start a job; returns the status code
    function automatic logic [1:0] open_job(logic [15:0] total);
        int dc;
        int sum;
        int rem;
        dc = eff_devs();
        sum = 0;
        for (int d = 0; d < NDEV; d++) begin
            final_q[d] = '0;
            given[d]   = '0;
        end
        tasks_done = '0;
        cur_dev    = '0;
        run_open   = 1'b0;
        job_total  = total;
        job_active = 1'b0;
        used_devs  = '0;
        if (total <= dc) begin
            for (int d = 0; d < total; d++) final_q[d] = 16'd1;
            used_devs  = total[3:0];
            job_active = total != 0;
            return ST_OK;
        end
        for (int d = 0; d < dc; d++) sum += base_q[d];
        if (sum > total) return ST_BAD;
        rem = total - sum;
        for (int d = 0; d < dc; d++)
            final_q[d] = 16'(base_q[d] + rem / dc + ((d < rem % dc) ? 1 : 0));
        used_devs  = 4'(dc);
        job_active = 1'b1;
        return ST_OK;
    endfunction

    // work out the result of one command and advance the shadow state
    function automatic t_res next_assignment(t_cmd c);
        t_res r;
        bit   stay;
        bit   found;
        int   n;
        int   first;
        int   d;
        r = '0;
        if (c.mode == MODE_LOAD) begin
            if (c.device_sel < eff_devs()) base_q[c.device_sel] = c.value;
            else r.status = ST_BAD;
        end else if (c.mode == MODE_START) begin
            r.status = open_job(c.value);
        end else if (c.mode == MODE_REQ) begin
            if (!job_active) begin
                r.status = ST_IDLE;
            end else begin
                stay = run_open && room(cur_dev) &&
                       (chunk == 0 || tasks_done % chunk != 0);
                found = stay;
                if (!stay) begin
                    n = used_devs;
                    if (n == 0) n = 1;
                    if (n > NDEV) n = NDEV;
                    first = run_open ? cur_dev + 1 : cur_dev;
                    for (int k = 0; k < n && !found; k++) begin
                        d = (first + k) % n;
                        if (room(d)) begin
                            cur_dev = 3'(d);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    job_active = 1'b0;
                    run_open   = 1'b0;
                    r.status   = ST_IDLE;
                end else begin
                    r.device_out = cur_dev;
                    r.slot       = given[cur_dev];
                    r.task_id    = tasks_done;
                    given[cur_dev] = given[cur_dev] + 16'd1;
                    tasks_done = tasks_done + 16'd1;
                    run_open = 1'b1;
                    if (tasks_done == job_total) begin
                        r.last     = 1'b1;
                        job_active = 1'b0;
                        run_open   = 1'b0;
                    end
                end
            end
        end else begin
            r.status = ST_BAD;
        end
        r.active_devices = used_devs;
        return r;
    endfunction

    task automatic cmp(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            o_errors++;
        end
    endtask

    // watch config writes, accepted commands and result beats
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            dev_count = RST_DEVICE_COUNT;
            chunk     = RST_CHUNK_LEN;
            clear_state();
            assign_q.delete();
            o_errors = 0;
        end else begin
            if (o_done) begin
                if (assign_q.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_errors++;
                end else begin
                    e = assign_q.pop_front();
                    cmp("status", e.status, o_res.status);
                    cmp("device_out", e.device_out, o_res.device_out);
                    cmp("slot", e.slot, o_res.slot);
                    cmp("task_id", e.task_id, o_res.task_id);
                    cmp("active_devices", e.active_devices, o_res.active_devices);
                    cmp("last", e.last, o_res.last);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_DEVICE_COUNT) dev_count = pwdata[3:0];
                else chunk = pwdata[15:0];
            end
            if (start && !busy) assign_q.push_back(next_assignment(i_cmd));
        end
    end
endmodule

// ===== bench/quota_chunk_task_distributor_core_tb.sv =====
module quota_chunk_task_distributor_core_tb;
    import qctd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int N_ITEMS   = 1550;
    localparam int TAIL_FROM = 1400;
    localparam int MAX_CYCLES = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_done;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          sent;
    int          cycles = 0;
    int          dc_now;

    quota_chunk_task_distributor_core u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_done, .o_res,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    quota_chunk_task_distributor_core_chk u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_done, .o_res,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("quota_chunk_task_distributor_core_tb NOT OK");
            $finish;
        end
    end

    // one command beat; called at a falling edge, returns at a falling edge
    task automatic issue(logic [1:0] mode, logic [2:0] sel, logic [15:0] val);
        bit ok;
        if (sent < TAIL_FROM && $urandom_range(7) == 0)
            repeat ($urandom_range(19, 1)) @(negedge i_clk);
        start = 1'b1;
        i_cmd = '{mode: mode, device_sel: sel, value: val};
        do begin
            ok = !busy;
            @(negedge i_clk);
        end while (!ok);
        start = 1'b0;
        sent++;
    endtask

    task automatic reg_write(logic idx, logic [31:0] data);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(negedge i_clk); while (!pready);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == REG_DEVICE_COUNT)
            dc_now = data[3:0] == 0 ? 1 : (data[3:0] > 8 ? 8 : data[3:0]);
    endtask

    // let all results come back, then give a slow start or divider time to settle
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_config();
        logic [15:0] ch;
        case ($urandom_range(5))
            0: ch = 16'd0;
            1: ch = 16'd1;
            2: ch = 16'hFFFF;
            3: ch = 16'($urandom_range(7, 2));
            4: ch = 16'($urandom);
            default: ch = 16'($urandom_range(20));
        endcase
        drain();
        reg_write(REG_DEVICE_COUNT, $urandom_range(3) == 0 ? $urandom_range(15)
                                                            : $urandom_range(8, 1));
        reg_write(REG_CHUNK_LEN, {16'($urandom), ch});
    endtask

    // quota loads, a start and requests, for small jobs up to three past the job's end, with some noise
    task automatic job_phase();
        int total;
        int nreq;
        for (int d = 0; d < 8; d++)
            if ($urandom_range(2) != 0)
                issue(MODE_LOAD, 3'(d), $urandom_range(15) == 0 ? 16'($urandom)
                                                                 : 16'($urandom_range(6)));
        case ($urandom_range(9))
            0: total = $urandom_range(dc_now);
            1: total = $urandom;
            default: total = $urandom_range(45);
        endcase
        issue(MODE_START, 3'($urandom), 16'(total));
        nreq = total > 50 ? $urandom_range(20) : total + $urandom_range(3);
        for (int i = 0; i < nreq; i++) begin
            if ($urandom_range(24) == 0)
                issue(2'($urandom), 3'($urandom), 16'($urandom));
            else
                issue(MODE_REQ, 3'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        start = 1'b0; i_cmd = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        sent = 0; dc_now = 8;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty job, small job, odd modes, quota overflow
        issue(MODE_REQ, 3'd0, 16'd0);
        issue(MODE_UNUSED, 3'd7, 16'hFFFF);
        issue(MODE_START, 3'd0, 16'd0);
        issue(MODE_START, 3'd0, 16'd3);
        repeat (4) issue(MODE_REQ, 3'd0, 16'd0);
        issue(MODE_LOAD, 3'd0, 16'hFFFF);
        issue(MODE_START, 3'd0, 16'd20);
        issue(MODE_LOAD, 3'd0, 16'd2);
        issue(MODE_LOAD, 3'd7, 16'd0);
        issue(MODE_START, 3'd7, 16'd21);
        repeat (6) issue(MODE_REQ, 3'd0, 16'd0);
        issue(MODE_LOAD, 3'd1, 16'd5);
        issue(MODE_START, 3'd0, 16'hFFFF);
        repeat (2) issue(MODE_REQ, 3'd0, 16'd0);
        drain();
        reg_write(REG_DEVICE_COUNT, 32'd3);
        reg_write(REG_CHUNK_LEN, 32'd0);
        issue(MODE_LOAD, 3'd5, 16'd1);
        issue(MODE_START, 3'd0, 16'd10);
        repeat (3) issue(MODE_REQ, 3'd0, 16'd0);

        while (sent < N_ITEMS) begin
            if ($urandom_range(2) == 0) set_config();
            job_phase();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("quota_chunk_task_distributor_core_tb OK");
        else
            $display("quota_chunk_task_distributor_core_tb NOT OK");
        $finish;
    end
endmodule
